/* src/xed_pkg.sv */
`timescale 1ns / 1ps
// Package for the XML entity decoder: word types, group type, constants.
// No dependencies; used by every module of the decoder.
package xed_pkg;

    localparam int MAX_ENTITY_BODY_DEF  = 16;
    localparam int MAX_OUTPUT_LIMIT_DEF = 4096;

    localparam int          CFG_W     = 13;
    localparam logic [12:0] CFG_RESET = 13'd4096;
    localparam logic        REG_MAX_OUTPUT_LENGTH = 1'b0;

    localparam int GROUP_DEPTH = 4;

    localparam logic [20:0] CODE_MAX  = 21'h10ffff;
    localparam logic [20:0] SURR_LO   = 21'h00d800;
    localparam logic [20:0] SURR_HI   = 21'h00dfff;
    localparam logic [20:0] CTRL_TOP  = 21'h000020;
    localparam logic [20:0] ONE_MAX   = 21'h00007f;
    localparam logic [20:0] TWO_MAX   = 21'h0007ff;
    localparam logic [20:0] THREE_MAX = 21'h00ffff;

    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] LEAD4 = 8'hf0;
    localparam logic [7:0] CONT  = 8'h80;
    localparam logic [5:0] CONT_MASK = 6'h3f;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;

    localparam logic [31:0] ENT_AMP  = 32'h00616d70;
    localparam logic [31:0] ENT_LT   = 32'h00006c74;
    localparam logic [31:0] ENT_GT   = 32'h00006774;
    localparam logic [31:0] ENT_QUOT = 32'h71756f74;
    localparam logic [31:0] ENT_APOS = 32'h61706f73;

    localparam logic [7:0] CP_AMP  = 8'h26;
    localparam logic [7:0] CP_LT   = 8'h3c;
    localparam logic [7:0] CP_GT   = 8'h3e;
    localparam logic [7:0] CP_QUOT = 8'h22;
    localparam logic [7:0] CP_APOS = 8'h27;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       string_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_done;
        logic       failed;
    } t_out_word;

    // results of one input word: count 0 with done set is a bare end marker
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            done;
        logic            failed;
    } t_group;

endpackage

/* src/xed_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input words, tracks entity/string state, forms result groups.
// Depends on xed_pkg.
module xed_front #(
    parameter int MAX_ENTITY_BODY  = xed_pkg::MAX_ENTITY_BODY_DEF,
    parameter int MAX_OUTPUT_LIMIT = xed_pkg::MAX_OUTPUT_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  xed_pkg::t_in_word            i_word,
    input  logic                         i_full,
    input  logic [xed_pkg::CFG_W-1:0]    i_max_len,
    output logic                         o_grp_push,
    output xed_pkg::t_group              o_grp
);

    localparam int BL_W  = $clog2(MAX_ENTITY_BODY + 1);
    localparam int CNT_W = $clog2(MAX_OUTPUT_LIMIT + 1);
    localparam int CMP_W = ((CNT_W > xed_pkg::CFG_W) ? CNT_W : xed_pkg::CFG_W) + 1;

    logic            r_in_ent,  n_in_ent;
    logic [BL_W-1:0] r_bl,      n_bl;
    logic [31:0]     r_head,    n_head;
    logic            r_is_hex,  n_is_hex;
    logic [20:0]     r_code,    n_code;
    logic            r_num_bad, n_num_bad;
    logic [CNT_W-1:0] r_count,  n_count;
    logic            r_err,     n_err;

    logic [7:0]       b;
    logic             take;
    logic [CMP_W-1:0] lim, cnt_ext;
    logic             plain_fit;

    logic             dig_dec, dig_lo, dig_up, dig_ok;
    logic [3:0]       dig_val;
    logic [24:0]      mul, nv;
    logic             nv_over;

    logic [7:0]       head_first;
    logic             is_name, is_num, known;
    logic [20:0]      cp;
    logic             cp_bad;
    logic [3:0][7:0]  utf;
    logic [2:0]       utf_len;
    logic             close_fit, close_ok;

    assign b    = i_word.in_byte;
    assign take = i_push & ~i_full;

    assign lim = (CMP_W'(i_max_len) > CMP_W'(MAX_OUTPUT_LIMIT))
               ? CMP_W'(MAX_OUTPUT_LIMIT) : CMP_W'(i_max_len);
    assign cnt_ext   = CMP_W'(r_count);
    assign plain_fit = (cnt_ext + CMP_W'(1)) < lim;

    assign dig_dec = (b >= xed_pkg::CH_0) && (b <= xed_pkg::CH_9);
    assign dig_lo  = r_is_hex && (b >= xed_pkg::CH_A_LO) && (b <= xed_pkg::CH_F_LO);
    assign dig_up  = r_is_hex && (b >= xed_pkg::CH_A_UP) && (b <= xed_pkg::CH_F_UP);
    assign dig_ok  = dig_dec | dig_lo | dig_up;

    always_comb begin
        if (dig_dec) begin
            dig_val = 4'(b - xed_pkg::CH_0);
        end else if (dig_lo) begin
            dig_val = 4'(b - xed_pkg::CH_A_LO + 8'd10);
        end else begin
            dig_val = 4'(b - xed_pkg::CH_A_UP + 8'd10);
        end
    end

    assign mul = r_is_hex ? {r_code, 4'b0000}
                          : ({1'b0, r_code, 3'b000} + {3'b000, r_code, 1'b0});
    assign nv      = mul + 25'(dig_val);
    assign nv_over = nv > 25'(xed_pkg::CODE_MAX);

    always_comb begin
        if (r_bl >= BL_W'(4)) begin
            head_first = r_head[31:24];
        end else if (r_bl == BL_W'(3)) begin
            head_first = r_head[23:16];
        end else if (r_bl == BL_W'(2)) begin
            head_first = r_head[15:8];
        end else begin
            head_first = r_head[7:0];
        end
    end

    always_comb begin
        is_name = 1'b1;
        cp      = r_code;
        if (r_bl == BL_W'(3) && r_head == xed_pkg::ENT_AMP) begin
            cp = 21'(xed_pkg::CP_AMP);
        end else if (r_bl == BL_W'(2) && r_head == xed_pkg::ENT_LT) begin
            cp = 21'(xed_pkg::CP_LT);
        end else if (r_bl == BL_W'(2) && r_head == xed_pkg::ENT_GT) begin
            cp = 21'(xed_pkg::CP_GT);
        end else if (r_bl == BL_W'(4) && r_head == xed_pkg::ENT_QUOT) begin
            cp = 21'(xed_pkg::CP_QUOT);
        end else if (r_bl == BL_W'(4) && r_head == xed_pkg::ENT_APOS) begin
            cp = 21'(xed_pkg::CP_APOS);
        end else begin
            is_name = 1'b0;
        end
    end

    assign is_num = (r_bl >= BL_W'(2)) && (head_first == xed_pkg::CH_HASH)
                  && !(r_is_hex && r_bl == BL_W'(2)) && !r_num_bad;
    assign known  = (r_bl != '0) && (is_name || is_num);

    assign cp_bad = ((cp < xed_pkg::CTRL_TOP) && (cp != 21'(xed_pkg::CH_TAB))
                     && (cp != 21'(xed_pkg::CH_LF)) && (cp != 21'(xed_pkg::CH_CR)))
                  || ((cp >= xed_pkg::SURR_LO) && (cp <= xed_pkg::SURR_HI))
                  || (cp > xed_pkg::CODE_MAX);

    always_comb begin
        utf = '0;
        if (cp <= xed_pkg::ONE_MAX) begin
            utf[0]  = cp[7:0];
            utf_len = 3'd1;
        end else if (cp <= xed_pkg::TWO_MAX) begin
            utf[0]  = xed_pkg::LEAD2 | {3'b000, cp[10:6]};
            utf[1]  = xed_pkg::CONT | {2'b00, cp[5:0] & xed_pkg::CONT_MASK};
            utf_len = 3'd2;
        end else if (cp <= xed_pkg::THREE_MAX) begin
            utf[0]  = xed_pkg::LEAD3 | {4'b0000, cp[15:12]};
            utf[1]  = xed_pkg::CONT | {2'b00, cp[11:6]};
            utf[2]  = xed_pkg::CONT | {2'b00, cp[5:0]};
            utf_len = 3'd3;
        end else begin
            utf[0]  = xed_pkg::LEAD4 | {5'b00000, cp[20:18]};
            utf[1]  = xed_pkg::CONT | {2'b00, cp[17:12]};
            utf[2]  = xed_pkg::CONT | {2'b00, cp[11:6]};
            utf[3]  = xed_pkg::CONT | {2'b00, cp[5:0]};
            utf_len = 3'd4;
        end
    end

    assign close_fit = (cnt_ext + CMP_W'(utf_len)) < lim;
    assign close_ok  = known && !cp_bad && close_fit;

    always_comb begin
        n_in_ent   = r_in_ent;
        n_bl       = r_bl;
        n_head     = r_head;
        n_is_hex   = r_is_hex;
        n_code     = r_code;
        n_num_bad  = r_num_bad;
        n_count    = r_count;
        n_err      = r_err;
        o_grp      = '0;
        o_grp_push = 1'b0;
        if (take) begin
            if (i_word.byte_present && !r_err) begin
                if (r_in_ent) begin
                    if (b == xed_pkg::CH_SEMI) begin
                        n_in_ent = 1'b0;
                        if (close_ok) begin
                            o_grp.bytes = utf;
                            o_grp.count = utf_len;
                            n_count     = r_count + CNT_W'(utf_len);
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (r_bl >= BL_W'(MAX_ENTITY_BODY)) begin
                        n_err = 1'b1;
                    end else begin
                        if (r_bl < BL_W'(4)) begin
                            n_head = {r_head[23:0], b};
                        end
                        if (r_bl == BL_W'(1) && (b == xed_pkg::CH_X_LO || b == xed_pkg::CH_X_UP)) begin
                            n_is_hex = 1'b1;
                        end else if (r_bl >= BL_W'(1)) begin
                            if (!dig_ok) begin
                                n_num_bad = 1'b1;
                            end else if (!r_num_bad) begin
                                if (nv_over) begin
                                    n_num_bad = 1'b1;
                                end else begin
                                    n_code = nv[20:0];
                                end
                            end
                        end
                        n_bl = r_bl + BL_W'(1);
                    end
                end else if (b == xed_pkg::CH_AMP) begin
                    n_in_ent  = 1'b1;
                    n_bl      = '0;
                    n_head    = '0;
                    n_is_hex  = 1'b0;
                    n_code    = '0;
                    n_num_bad = 1'b0;
                end else if (b == xed_pkg::CH_LT || !plain_fit) begin
                    n_err = 1'b1;
                end else begin
                    o_grp.bytes[0] = b;
                    o_grp.count    = 3'd1;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            if (i_word.string_end) begin
                o_grp.done   = 1'b1;
                o_grp.failed = n_err | n_in_ent;
                n_in_ent     = 1'b0;
                n_bl         = '0;
                n_head       = '0;
                n_is_hex     = 1'b0;
                n_code       = '0;
                n_num_bad    = 1'b0;
                n_count      = '0;
                n_err        = 1'b0;
            end
            o_grp_push = (o_grp.count != 3'd0) || i_word.string_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ent  <= 1'b0;
            r_bl      <= '0;
            r_head    <= '0;
            r_is_hex  <= 1'b0;
            r_code    <= '0;
            r_num_bad <= 1'b0;
            r_count   <= '0;
            r_err     <= 1'b0;
        end else begin
            r_in_ent  <= n_in_ent;
            r_bl      <= n_bl;
            r_head    <= n_head;
            r_is_hex  <= n_is_hex;
            r_code    <= n_code;
            r_num_bad <= n_num_bad;
            r_count   <= n_count;
            r_err     <= n_err;
        end
    end

endmodule

/* src/xed_fifo.sv */
`timescale 1ns / 1ps
// Short queue of result groups between front and back end.
// Depends on xed_pkg.
module xed_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xed_pkg::t_group i_grp,
    input  logic            i_pop,
    output xed_pkg::t_group o_grp,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(xed_pkg::GROUP_DEPTH);
    localparam int CNT_W = $clog2(xed_pkg::GROUP_DEPTH + 1);

    xed_pkg::t_group  r_mem [xed_pkg::GROUP_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == CNT_W'(xed_pkg::GROUP_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_grp   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
        end
    end

endmodule

/* src/xed_back.sv */
`timescale 1ns / 1ps
// Back end: serializes result groups into single output words, output register.
// Depends on xed_pkg.
module xed_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xed_pkg::t_group   i_grp,
    input  logic              i_grp_empty,
    output logic              o_grp_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output xed_pkg::t_out_word o_word
);

    logic               r_valid;
    logic [1:0]         r_idx;
    xed_pkg::t_out_word r_word, n_word;
    logic [1:0]         last_idx;
    logic               is_last, load;

    assign last_idx = (i_grp.count == 3'd0) ? 2'd0 : 2'(i_grp.count - 3'd1);
    assign is_last  = r_idx == last_idx;
    assign load     = !i_grp_empty && (!r_valid || i_pop);
    assign o_grp_pop = load && is_last;

    always_comb begin
        n_word.byte_valid  = i_grp.count != 3'd0;
        n_word.out_byte    = n_word.byte_valid ? i_grp.bytes[r_idx] : 8'd0;
        n_word.run_last    = is_last;
        n_word.string_done = is_last & i_grp.done;
        n_word.failed      = is_last & i_grp.done & i_grp.failed;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty = ~r_valid;
    assign o_word  = r_word;

endmodule

/* src/xml_entity_decoder_utf8.sv */
`timescale 1ns / 1ps
// XML attribute entity decoder with UTF-8 output; top level with config port.
// Path: an accepted word's results go through the group queue to the output register.
// Throughput: one input word per cycle while not full; one result per cycle while
// popped, so an entity of k UTF-8 bytes gives k results, absorbed by a 4-group queue.
// Reset: synchronous, active low; clears all control state, max_output_length to 4096.
// Depends on xed_pkg, xed_front, xed_fifo, xed_back.
module xml_entity_decoder_utf8 #(
    parameter int MAX_ENTITY_BODY  = xed_pkg::MAX_ENTITY_BODY_DEF,
    parameter int MAX_OUTPUT_LIMIT = xed_pkg::MAX_OUTPUT_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  xed_pkg::t_in_word  i_data,
    output logic               empty,
    input  logic               pop,
    output xed_pkg::t_out_word o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [xed_pkg::CFG_W-1:0] r_max_len;
    logic                      w_grp_push, w_grp_pop, w_fifo_full, w_fifo_empty;
    xed_pkg::t_group           w_grp_in, w_grp_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == xed_pkg::REG_MAX_OUTPUT_LENGTH)
                  ? 32'(r_max_len) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= xed_pkg::CFG_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == xed_pkg::REG_MAX_OUTPUT_LENGTH) begin
            r_max_len <= pwdata[xed_pkg::CFG_W-1:0];
        end
    end

    assign full = w_fifo_full;

    xed_front #(
        .MAX_ENTITY_BODY  (MAX_ENTITY_BODY),
        .MAX_OUTPUT_LIMIT (MAX_OUTPUT_LIMIT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_word     (i_data),
        .i_full     (w_fifo_full),
        .i_max_len  (r_max_len),
        .o_grp_push (w_grp_push),
        .o_grp      (w_grp_in)
    );

    xed_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_grp_push),
        .i_grp   (w_grp_in),
        .i_pop   (w_grp_pop),
        .o_grp   (w_grp_out),
        .o_full  (w_fifo_full),
        .o_empty (w_fifo_empty)
    );

    xed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (w_grp_out),
        .i_grp_empty (w_fifo_empty),
        .o_grp_pop   (w_grp_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_word      (o_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_full |-> !w_grp_push)
        else $error("group pushed into full queue");

    a_bare_word_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.byte_valid) |-> (o_data.string_done && o_data.run_last))
        else $error("result without data byte is not a string end");

    a_fail_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.failed) |-> o_data.string_done)
        else $error("failed set without string_done");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.string_done) |-> o_data.run_last)
        else $error("string_done on a non-final result");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for xml_entity_decoder_utf8: directed and random attribute strings,
// checked against an in-bench entity decoder. Depends on xed_pkg and the RTL.
module tb_top;

    localparam int          LIMIT_CYCLES = 300000;
    localparam int          SETTLE       = 8;
    localparam logic [2:0]  CFG_ADDR     = 3'(4 * xed_pkg::REG_MAX_OUTPUT_LENGTH);
    localparam int          N_PHASES     = 6;
    localparam int          PHASE_LIMIT [N_PHASES] = '{1, 0, 8191, 24, 57, 4096};
    localparam int          PHASE_WORDS [N_PHASES] = '{30, 20, 60, 70, 70, 50};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    xed_pkg::t_in_word  i_data = '0;
    logic               empty;
    logic               pop = 1'b0;
    xed_pkg::t_out_word o_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    xml_entity_decoder_utf8 DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and expected output
    xed_pkg::t_in_word  raw_q [$];
    xed_pkg::t_out_word decoded_q [$];
    logic [7:0]  text_q [$];
    string       ent_names [5] = '{"amp", "lt", "gt", "quot", "apos"};

    // decoder state mirror
    logic [12:0] limit_reg = xed_pkg::CFG_RESET;
    logic        ent_open = 1'b0;
    int          body_len = 0;
    logic [31:0] body_head = '0;
    logic        hex_ref = 1'b0;
    int          code_acc = 0;
    logic        code_bad = 1'b0;
    int          out_count = 0;
    logic        str_err = 1'b0;

    int          errors = 0;
    int          made = 0;
    int          strings = 0;
    int          accepted = 0;
    int          results = 0;
    int          cycles = 0;
    logic        in_taken = 1'b0;
    logic        calm = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_cnt = 0;
    logic        hold_done = 1'b0;
    xed_pkg::t_out_word want;

    function void decode_step(xed_pkg::t_in_word w);
        logic [7:0]  ub [4];
        logic [7:0]  b;
        logic [7:0]  first;
        logic [20:0] cp;
        logic        ok;
        logic        fail;
        logic        last;
        int          n;
        int          dv;
        int          nv;
        int          lim;
        xed_pkg::t_out_word r;
        b = w.in_byte;
        n = 0;
        fail = 1'b0;
        lim = (limit_reg > xed_pkg::MAX_OUTPUT_LIMIT_DEF) ? xed_pkg::MAX_OUTPUT_LIMIT_DEF
                                                         : int'(limit_reg);
        if (w.byte_present && !str_err) begin
            if (ent_open) begin
                if (b == xed_pkg::CH_SEMI) begin
                    ent_open = 1'b0;
                    ok = 1'b1;
                    cp = '0;
                    if (body_len == 0) begin
                        ok = 1'b0;
                    end else begin
                        first = (body_len >= 4) ? body_head[31:24]
                                                : body_head[8*(body_len-1) +: 8];
                        if (body_len == 3 && body_head == xed_pkg::ENT_AMP)
                            cp = 21'(xed_pkg::CP_AMP);
                        else if (body_len == 2 && body_head == xed_pkg::ENT_LT)
                            cp = 21'(xed_pkg::CP_LT);
                        else if (body_len == 2 && body_head == xed_pkg::ENT_GT)
                            cp = 21'(xed_pkg::CP_GT);
                        else if (body_len == 4 && body_head == xed_pkg::ENT_QUOT)
                            cp = 21'(xed_pkg::CP_QUOT);
                        else if (body_len == 4 && body_head == xed_pkg::ENT_APOS)
                            cp = 21'(xed_pkg::CP_APOS);
                        else if (body_len >= 2 && first == xed_pkg::CH_HASH &&
                                 !(hex_ref && body_len == 2) && !code_bad)
                            cp = 21'(code_acc);
                        else ok = 1'b0;
                    end
                    if (ok && ((cp < xed_pkg::CTRL_TOP && cp != 21'(xed_pkg::CH_TAB) &&
                                cp != 21'(xed_pkg::CH_LF) && cp != 21'(xed_pkg::CH_CR)) ||
                               (cp >= xed_pkg::SURR_LO && cp <= xed_pkg::SURR_HI) ||
                               cp > xed_pkg::CODE_MAX))
                        ok = 1'b0;
                    if (!ok) begin
                        str_err = 1'b1;
                    end else begin
                        if (cp <= xed_pkg::ONE_MAX) begin
                            ub[0] = cp[7:0];
                            n = 1;
                        end else if (cp <= xed_pkg::TWO_MAX) begin
                            ub[0] = xed_pkg::LEAD2 | {3'b0, cp[10:6]};
                            ub[1] = xed_pkg::CONT | {2'b0, cp[5:0]};
                            n = 2;
                        end else if (cp <= xed_pkg::THREE_MAX) begin
                            ub[0] = xed_pkg::LEAD3 | {4'b0, cp[15:12]};
                            ub[1] = xed_pkg::CONT | {2'b0, cp[11:6]};
                            ub[2] = xed_pkg::CONT | {2'b0, cp[5:0]};
                            n = 3;
                        end else begin
                            ub[0] = xed_pkg::LEAD4 | {5'b0, cp[20:18]};
                            ub[1] = xed_pkg::CONT | {2'b0, cp[17:12]};
                            ub[2] = xed_pkg::CONT | {2'b0, cp[11:6]};
                            ub[3] = xed_pkg::CONT | {2'b0, cp[5:0]};
                            n = 4;
                        end
                        if (out_count + n >= lim) begin
                            str_err = 1'b1;
                            n = 0;
                        end else begin
                            out_count += n;
                        end
                    end
                end else if (body_len >= xed_pkg::MAX_ENTITY_BODY_DEF) begin
                    str_err = 1'b1;
                end else begin
                    if (body_len < 4) body_head = {body_head[23:0], b};
                    if (body_len == 1 && (b == xed_pkg::CH_X_LO || b == xed_pkg::CH_X_UP)) begin
                        hex_ref = 1'b1;
                    end else if (body_len >= 1) begin
                        dv = -1;
                        if (b >= xed_pkg::CH_0 && b <= xed_pkg::CH_9)
                            dv = b - xed_pkg::CH_0;
                        else if (hex_ref && b >= xed_pkg::CH_A_LO && b <= xed_pkg::CH_F_LO)
                            dv = b - xed_pkg::CH_A_LO + 10;
                        else if (hex_ref && b >= xed_pkg::CH_A_UP && b <= xed_pkg::CH_F_UP)
                            dv = b - xed_pkg::CH_A_UP + 10;
                        if (dv < 0) begin
                            code_bad = 1'b1;
                        end else if (!code_bad) begin
                            nv = code_acc * (hex_ref ? 16 : 10) + dv;
                            if (nv > int'(xed_pkg::CODE_MAX)) code_bad = 1'b1;
                            else code_acc = nv;
                        end
                    end
                    body_len++;
                end
            end else if (b == xed_pkg::CH_AMP) begin
                ent_open = 1'b1;
                body_len = 0;
                body_head = '0;
                hex_ref = 1'b0;
                code_acc = 0;
                code_bad = 1'b0;
            end else if (b == xed_pkg::CH_LT || out_count + 1 >= lim) begin
                str_err = 1'b1;
            end else begin
                ub[0] = b;
                n = 1;
                out_count++;
            end
        end
        if (w.string_end) begin
            if (ent_open) str_err = 1'b1;
            fail = str_err;
        end
        for (int k = 0; k < n; k++) begin
            last = (k == n - 1);
            r = xed_pkg::t_out_word'{ub[k], 1'b1, last, last && w.string_end,
                                     last && w.string_end && fail};
            decoded_q.push_back(r);
        end
        if (w.string_end && n == 0)
            decoded_q.push_back(xed_pkg::t_out_word'{8'h00, 1'b0, 1'b1, 1'b1, fail});
        if (w.string_end) begin
            ent_open = 1'b0;
            body_len = 0;
            body_head = '0;
            hex_ref = 1'b0;
            code_acc = 0;
            code_bad = 1'b0;
            out_count = 0;
            str_err = 1'b0;
        end
    endfunction

    function void cmp_field(string name, logic [7:0] e, logic [7:0] a);
        if (a !== e) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endfunction

    // monitor: input acceptance feeds the mirror, output words are checked
    always @(posedge i_clk) begin : word_monitor
        in_taken <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) begin
            decode_step(i_data);
            accepted++;
        end
        if (i_rst_n && pop && !empty) begin
            results++;
            if (decoded_q.size() == 0) begin
                $error("unexpected word: out_byte %0h done %0b", o_data.out_byte,
                       o_data.string_done);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                cmp_field("out_byte", want.out_byte, o_data.out_byte);
                cmp_field("byte_valid", 8'(want.byte_valid), 8'(o_data.byte_valid));
                cmp_field("run_last", 8'(want.run_last), 8'(o_data.run_last));
                cmp_field("string_done", 8'(want.string_done), 8'(o_data.string_done));
                cmp_field("failed", 8'(want.failed), 8'(o_data.failed));
            end
        end
    end

    always @(negedge i_clk) begin : word_driver
        if (in_taken) void'(raw_q.pop_front());
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !in_taken) begin
            push <= 1'b1;
        end else if (in_gap > 0) begin
            in_gap--;
            push <= 1'b0;
        end else if (raw_q.size() == 0) begin
            push <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 12) - 1;
            push <= 1'b0;
        end else begin
            push <= 1'b1;
            i_data <= raw_q[0];
        end
    end

    // receiver; one long hold-off lets the block back up into full
    always @(negedge i_clk) begin : word_sink
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else if (!hold_done && accepted >= 60) begin
            hold_done = 1'b1;
            hold_cnt = 300;
            pop <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(1, 12) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("[xml_entity_decoder_utf8] ERROR");
            $finish;
        end
    end

    task put_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // moves the staged string into the input queue, with stray ignored words
    task flush_string(bit end_on_byte);
        int last;
        last = text_q.size() - 1;
        for (int i = 0; i <= last; i++) begin
            if ($urandom_range(0, 19) == 0)
                raw_q.push_back(xed_pkg::t_in_word'{8'($urandom), 1'b0, 1'b0});
            raw_q.push_back(xed_pkg::t_in_word'{text_q[i], 1'b1,
                                                end_on_byte && i == last});
            made++;
        end
        if (!end_on_byte || last < 0) begin
            raw_q.push_back(xed_pkg::t_in_word'{8'($urandom), 1'b0, 1'b1});
            made++;
        end
        strings++;
        text_q.delete();
    endtask

    function int rand_code();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 'h1f);
            1: return $urandom_range('h20, 'h7f);
            2: return $urandom_range('h80, 'h7ff);
            3: return $urandom_range('h800, 'hffff);
            4: return $urandom_range('hd800, 'hdfff);
            5: return $urandom_range('h10000, 'h10ffff);
            6: return $urandom_range('h110000, 'h1fffff);
            default: begin
                case ($urandom_range(0, 9))
                    0: return 9;
                    1: return 10;
                    2: return 13;
                    3: return 'h7f;
                    4: return 'h80;
                    5: return 'h7ff;
                    6: return 'h800;
                    7: return 'hffff;
                    8: return 'h10000;
                    default: return 'h10ffff;
                endcase
            end
        endcase
    endfunction

    task add_token();
        int    k;
        int    v;
        string hs;
        string nm;
        k = $urandom_range(0, 99);
        if (k < 45) begin
            v = $urandom_range(0, 255);
            if (v == xed_pkg::CH_AMP || v == xed_pkg::CH_LT) v = $urandom_range('h61, 'h7a);
            text_q.push_back(8'(v));
        end else if (k < 60) begin
            nm = ent_names[$urandom_range(0, 4)];
            if ($urandom_range(0, 4) == 0)
                nm[$urandom_range(0, nm.len() - 1)] = 8'($urandom_range('h61, 'h7a));
            else if ($urandom_range(0, 9) == 0)
                nm = nm.toupper();
            put_text($sformatf("&%s;", nm));
        end else if (k < 78) begin
            put_text($sformatf("&#%0d;", rand_code()));
        end else if (k < 93) begin
            hs = $sformatf("%0h", rand_code());
            if ($urandom_range(0, 1)) hs = hs.toupper();
            if ($urandom_range(0, 4) == 0) hs = $sformatf("00%s", hs);
            put_text($sformatf("&#%s%s;", $urandom_range(0, 1) ? "x" : "X", hs));
        end else begin
            case ($urandom_range(0, 6))
                0: text_q.push_back(xed_pkg::CH_LT);
                1: text_q.push_back(8'($urandom));
                2: put_text("&;");
                3: put_text($urandom_range(0, 1) ? "&#;" : "&#x;");
                4: begin
                    put_text("&#");
                    repeat ($urandom_range(13, 18))
                        text_q.push_back(8'($urandom_range(xed_pkg::CH_0, xed_pkg::CH_9)));
                    text_q.push_back(xed_pkg::CH_SEMI);
                end
                5: put_text($sformatf("&#%0d%s;", $urandom_range(0, 99),
                                      $urandom_range(0, 1) ? "a" : "x"));
                default: put_text("&");
            endcase
        end
    endtask

    task fill_random(int n);
        int target;
        int ntok;
        target = made + n;
        while (made < target) begin
            ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 8);
            repeat (ntok) begin
                if (made + text_q.size() < target) add_token();
            end
            flush_string($urandom_range(0, 9) < 7);
        end
    endtask

    task drain();
        while (raw_q.size() != 0 || push || decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write followed by a read-back
    task cfg_write(int v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR;
        pwdata <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        limit_reg = 13'(v);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(limit_reg)) begin
            $error("max_output_length: expected %0h, got %0h", limit_reg, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        text_q.push_back(8'hff);
        text_q.push_back(8'h00);
        flush_string(1'b1);
        raw_q.push_back(xed_pkg::t_in_word'{8'h5a, 1'b0, 1'b0});
        put_text("&lt;");
        flush_string(1'b0);
        put_text("&#x1F600;");
        flush_string(1'b1);
        text_q.push_back(xed_pkg::CH_LT);
        flush_string(1'b1);
        put_text("&amp");
        flush_string(1'b0);
        fill_random(80);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES - 1) calm = 1'b1;
            cfg_write(PHASE_LIMIT[p]);
            fill_random(PHASE_WORDS[p]);
            drain();
        end

        $display("covered %0d input words in %0d strings, %0d output words checked,",
                 made, strings, results);
        $display("under %0d output limit settings incl. 0, 1 and the 13-bit maximum",
                 N_PHASES + 1);
        if (errors == 0) begin
            $display("[xml_entity_decoder_utf8] OK");
        end else begin
            $display("[xml_entity_decoder_utf8] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/xed_pkg.sv
src/xed_front.sv
src/xed_fifo.sv
src/xed_back.sv
src/xml_entity_decoder_utf8.sv
tb/sv/tb_top.sv
